/* src/irt_pkg.sv */
// Shared types, constants and helpers for the integer to radix text converter.
`timescale 1ns / 1ps

package irt_pkg;

	localparam int VALUE_W = 64;
	localparam int BASE_W  = 6;
	localparam int LEN_W   = 7;
	localparam int CHAR_W  = 8;
	localparam int DIGIT_W = 6;
	localparam int NB_W    = 4;

	localparam logic [BASE_W-1:0] MIN_BASE = 6'd2;
	localparam logic [BASE_W-1:0] MAX_BASE = 6'd36;
	localparam logic [BASE_W-1:0] DEC_BASE = 6'd10;

	localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;

	typedef enum logic [1:0] {
		REG_NUMBER_BASE = 2'd0,
		REG_FIELD_WIDTH = 2'd1,
		REG_PAD_CHAR    = 2'd2
	} reg_index_t;

	// One conversion as classified by the front end.
	typedef struct packed {
		logic               bad;
		logic               neg;
		logic [VALUE_W-1:0] mag;
		logic [BASE_W-1:0]  base;
		logic [LEN_W-1:0]   limit;
		logic               fixed;
		logic [CHAR_W-1:0]  pad;
	} job_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] offs;
		offs = (d < 6'd10) ? CHAR_ZERO : (CHAR_UPPER_A - 8'd10);
		return offs + CHAR_W'(d);
	endfunction

endpackage

/* src/irt_front.sv */
// Front end: configuration registers and classification of each input value.
`timescale 1ns / 1ps

module irt_front
	import irt_pkg::*;
#(
	parameter int MAX_CHARS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [VALUE_W-1:0] in_value,
	input  logic               in_signed,
	output logic               job_valid,
	input  logic               job_ready,
	output job_t               job
);

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_CHARS);

	logic [BASE_W-1:0] base_q;
	logic [LEN_W-1:0]  width_q;
	logic [CHAR_W-1:0] pad_q;
	logic              neg;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= DEC_BASE;
			width_q <= '0;
			pad_q   <= CHAR_SPACE;
		end else if (cfg_valid) begin
			case (reg_index_t'(cfg_index))
				REG_NUMBER_BASE: base_q  <= cfg_data[BASE_W-1:0];
				REG_FIELD_WIDTH: width_q <= cfg_data[LEN_W-1:0];
				REG_PAD_CHAR:    pad_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign neg = (base_q == DEC_BASE) && in_signed && in_value[VALUE_W-1];

	always_comb begin
		job.bad   = (base_q < MIN_BASE) || (base_q > MAX_BASE);
		job.neg   = neg;
		job.mag   = neg ? (VALUE_W'(0) - in_value) : in_value;
		job.base  = base_q;
		job.fixed = (width_q != '0);
		job.limit = ((width_q == '0) || (width_q > MAX_LEN)) ? MAX_LEN : width_q;
		job.pad   = pad_q;
	end

	assign job_valid = in_valid;
	assign in_ready  = job_ready;

endmodule

/* src/irt_queue.sv */
// Two-entry queue of classified conversions between front and back end.
`timescale 1ns / 1ps

module irt_queue
	import irt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  job_t push_job,
	output logic pop_valid,
	input  logic pop_ready,
	output job_t pop_job
);

	job_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] level_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (level_q != 2'd2);
	assign pop_valid  = (level_q != 2'd0);
	assign pop_job    = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			level_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop)  rd_ptr_q <= !rd_ptr_q;
			case ({do_push, do_pop})
				2'b10:   level_q <= level_q + 2'd1;
				2'b01:   level_q <= level_q - 2'd1;
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

/* src/irt_back.sv */
// Back end: byte-serial division into a digit store, then character emission.
`timescale 1ns / 1ps

module irt_back
	import irt_pkg::*;
#(
	parameter int MAX_CHARS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	output logic              job_ready,
	input  job_t              job,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CHAR_W-1:0] out_char,
	output logic              out_last,
	output logic              out_bad,
	output logic [LEN_W-1:0]  out_len
);

	localparam int ADDR_W = $clog2(MAX_CHARS);
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_CHARS);

	typedef enum logic [2:0] {
		ST_IDLE, ST_INIT, ST_DIV, ST_FIN, ST_PAD, ST_RD, ST_WR, ST_BAD
	} state_t;

	state_t             state_q;
	job_t               job_q;
	logic [VALUE_W-1:0] quot_q;
	logic [DIGIT_W-1:0] rem_q;
	logic [2:0]         byte_q;
	logic [NB_W-1:0]    nb_q;
	logic [LEN_W-1:0]   cnt_q;
	logic [LEN_W-1:0]   total_q;
	logic [LEN_W-1:0]   pads_q;
	logic [LEN_W-1:0]   pos_q;
	logic [LEN_W-1:0]   minus_pos_q;
	logic               minus_q;
	logic [LEN_W-1:0]   rd_idx_q;
	logic [DIGIT_W-1:0] rd_data_q;
	logic               out_valid_q;
	logic [CHAR_W-1:0]  out_char_q;
	logic               out_last_q;
	logic               out_bad_q;
	logic [LEN_W-1:0]   out_len_q;

	logic [DIGIT_W-1:0] digit_mem [MAX_CHARS];

	logic [13:0]        div_res;
	logic [VALUE_W-1:0] quot_next;
	logic [NB_W-1:0]    nb_init;
	logic [NB_W-1:0]    nb_next;
	logic [LEN_W-1:0]   cnt_inc;
	logic               out_free;
	logic               emit;
	logic               mem_we;
	logic               neg_eff;
	logic [LEN_W-1:0]   total_c;
	logic [LEN_W-1:0]   pads_c;

	// Eight steps of restoring division of one quotient byte by the radix.
	function automatic logic [13:0] div_byte(input logic [DIGIT_W-1:0] rem_in,
			input logic [7:0] num, input logic [BASE_W-1:0] base);
		logic [6:0]         t;
		logic [DIGIT_W-1:0] r;
		logic [7:0]         qb;
		r  = rem_in;
		qb = '0;
		for (int k = 7; k >= 0; k--) begin
			t = {r, num[k]};
			if (t >= {1'b0, base}) begin
				r     = DIGIT_W'(t - {1'b0, base});
				qb[k] = 1'b1;
			end else begin
				r = t[DIGIT_W-1:0];
			end
		end
		return {qb, r};
	endfunction

	assign div_res = div_byte(rem_q, quot_q[byte_q*8 +: 8], job_q.base);

	always_comb begin
		quot_next = quot_q;
		quot_next[byte_q*8 +: 8] = div_res[13:6];
	end

	always_comb begin
		nb_init = NB_W'(1);
		for (int k = 0; k < 8; k++) begin
			if (quot_q[k*8 +: 8] != 8'd0) nb_init = NB_W'(k + 1);
		end
	end

	// The quotient loses at most one significant byte per division.
	assign nb_next = ((nb_q > NB_W'(1)) && (quot_next[3'(nb_q - NB_W'(1))*8 +: 8] == 8'd0))
		? (nb_q - NB_W'(1)) : nb_q;
	assign cnt_inc  = cnt_q + LEN_W'(1);
	assign out_free = !out_valid_q || out_ready;
	assign emit     = out_free &&
		((state_q == ST_PAD) || (state_q == ST_WR) || (state_q == ST_BAD));
	assign mem_we   = (state_q == ST_DIV) && (byte_q == 3'd0);

	always_comb begin
		neg_eff = job_q.neg;
		if (!job_q.fixed && (cnt_q >= MAX_LEN)) neg_eff = 1'b0;
		total_c = job_q.fixed ? job_q.limit : (cnt_q + LEN_W'(neg_eff));
		pads_c  = total_c - cnt_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			digit_mem[cnt_q[ADDR_W-1:0]] <= div_res[DIGIT_W-1:0];
		end
		rd_data_q <= digit_mem[rd_idx_q[ADDR_W-1:0]];
	end

	assign job_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;
	assign out_bad   = out_bad_q;
	assign out_len   = out_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			quot_q      <= '0;
			cnt_q       <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						job_q   <= job;
						quot_q  <= job.mag;
						state_q <= job.bad ? ST_BAD : ST_INIT;
					end
				end
				ST_INIT: begin
					nb_q    <= nb_init;
					byte_q  <= 3'(nb_init - NB_W'(1));
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					quot_q <= quot_next;
					if (byte_q != 3'd0) begin
						rem_q  <= div_res[DIGIT_W-1:0];
						byte_q <= byte_q - 3'd1;
					end else begin
						cnt_q  <= cnt_inc;
						rem_q  <= '0;
						nb_q   <= nb_next;
						byte_q <= 3'(nb_next - NB_W'(1));
						if ((quot_next == '0) || (cnt_inc >= job_q.limit)) begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					total_q     <= total_c;
					pads_q      <= pads_c;
					minus_q     <= neg_eff && (pads_c != '0);
					minus_pos_q <= (job_q.fixed && (job_q.pad == CHAR_ZERO))
						? '0 : (pads_c - LEN_W'(1));
					pos_q       <= '0;
					rd_idx_q    <= cnt_q - LEN_W'(1);
					state_q     <= (pads_c != '0) ? ST_PAD : ST_RD;
				end
				ST_PAD: begin
					if (out_free) begin
						out_char_q  <= (minus_q && (pos_q == minus_pos_q)) ? CHAR_MINUS : job_q.pad;
						out_last_q  <= 1'b0;
						out_bad_q   <= 1'b0;
						out_len_q   <= '0;
						pos_q       <= pos_q + LEN_W'(1);
						if (pos_q + LEN_W'(1) == pads_q) state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_WR;
				end
				ST_WR: begin
					if (out_free) begin
						out_char_q  <= digit_char(rd_data_q);
						out_last_q  <= (rd_idx_q == '0);
						out_bad_q   <= 1'b0;
						out_len_q   <= (rd_idx_q == '0) ? total_q : '0;
						rd_idx_q    <= rd_idx_q - LEN_W'(1);
						state_q     <= (rd_idx_q == '0) ? ST_IDLE : ST_RD;
					end
				end
				ST_BAD: begin
					if (out_free) begin
						out_char_q  <= '0;
						out_last_q  <= 1'b1;
						out_bad_q   <= 1'b1;
						out_len_q   <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* src/integer_to_radix_text.sv */
// Top level of the integer to radix text converter.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake                      Contents
//  s_axis    in         s_axis_tvalid / s_axis_tready  value_bits, signed_flag
//  m_axis    out        m_axis_tvalid / m_axis_tready  char_code, text_length, last, bad_radix
//  cfg       in         cfg_valid / cfg_ready          register index and data
//
// Each conversion is loaded, its significant bytes (1 to 8) are found, and each digit is made by
// dividing the quotient by the radix from its top significant byte down, one byte divided by the
// radix per cycle. The text is then sized, fill characters are sent, and each digit is read back
// through the digit store's read port and sent. A bad radix gives a lone error result. Reset
// clears the state, output valid flag, quotient and digit count; the digit store needs no clearing.
// Two classified values queue ahead of the converter, so the input stalls only when it is full.

module integer_to_radix_text
	import irt_pkg::*;
#(
	parameter int MAX_CHARS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [7:0]   cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [63:0]  s_axis_tdata,  // [63:0] value_bits
	input  logic         s_axis_tuser,  // [0] signed_flag
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [15:0]  m_axis_tdata,  // [7:0] char_code, [14:8] text_length, [15] zero
	output logic         m_axis_tlast,
	output logic         m_axis_tuser   // [0] bad_radix
);

	logic              front_valid;
	logic              front_ready;
	job_t              front_job;
	logic              back_valid;
	logic              back_ready;
	job_t              back_job;
	logic [CHAR_W-1:0] out_char;
	logic [LEN_W-1:0]  out_len;

	irt_front #(.MAX_CHARS(MAX_CHARS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_value  (s_axis_tdata),
		.in_signed (s_axis_tuser),
		.job_valid (front_valid),
		.job_ready (front_ready),
		.job       (front_job)
	);

	irt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_job   (front_job),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_job    (back_job)
	);

	irt_back #(.MAX_CHARS(MAX_CHARS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (back_valid),
		.job_ready (back_ready),
		.job       (back_job),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (out_char),
		.out_last  (m_axis_tlast),
		.out_bad   (m_axis_tuser),
		.out_len   (out_len)
	);

	assign m_axis_tdata = {1'b0, out_len, out_char};

	// An error result is a lone transfer with no character and no length.
	a_bad_is_lone: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
			m_axis_tlast && (m_axis_tdata[7:0] == 8'd0) && (m_axis_tdata[14:8] == 7'd0))
		else $error("error result carries a character or length");

	// The length appears only on the final character.
	a_len_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> (m_axis_tdata[14:8] == 7'd0))
		else $error("text length on a character that is not the last");

	// A real conversion always reports between one and MAX_CHARS characters.
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast && !m_axis_tuser |->
			(m_axis_tdata[14:8] != 7'd0) && (m_axis_tdata[14:8] <= 7'(MAX_CHARS)))
		else $error("text length out of range");

endmodule
